[rtl/sft_pkg.sv]
// Package for the sorted fact table: default sizes, stream field widths
// and request codes used by the table core.
// Depends on nothing.
`default_nettype none

package sft_pkg;

    // Default table sizes.
    localparam int unsigned DefCapacity  = 64;
    localparam int unsigned DefKeyBits   = 16;
    localparam int unsigned DefValueBits = 16;

    // Fixed widths of the stream fields.
    localparam int unsigned ReqTypeW    = 2;
    localparam int unsigned VarIdW      = 16;
    localparam int unsigned NewValueW   = 16;
    localparam int unsigned ReadValueW  = 16;
    localparam int unsigned EntryCountW = 7;

    // Packed stream widths (data filled up to whole bytes).
    localparam int unsigned InDataW  = 32;
    localparam int unsigned InUserW  = 2;
    localparam int unsigned OutDataW = 24;
    localparam int unsigned OutUserW = 2;

    // Request codes.
    typedef enum logic [ReqTypeW-1:0] {
        REQ_SET   = 2'd0,
        REQ_GET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

endpackage

`default_nettype wire

[rtl/sorted_fact_table_core.sv]
// Sorted fact table core: a sorted (variable, value) map with set, get and clear.
// Depends on sft_pkg and sft_ram.
//
//  Channel   Direction  Ports                  Contents
//  s_axis    in         tvalid/tready/tdata/   request: tuser = req_type,
//                       tuser                  tdata = var_id, new_value
//  m_axis    out        tvalid/tready/tdata/   result: tdata = read_value,
//                       tuser                  entry_count; tuser = found, overflow
//
// One request is handled at a time. A get or set walks the key store from
// entry 0, one entry at a time (memory read, then compare), until it
// reaches the sorted position. An insert then moves each larger entry up
// one slot (memory read, then write) before the new entry is written.
// Clear and the unused code go straight to the result. The result is
// held in an output register until taken; the request side is ready again
// once the result has left. Reset empties the table at once.
`default_nettype none

module sorted_fact_table_core #(
    parameter int unsigned CAPACITY   = sft_pkg::DefCapacity,
    parameter int unsigned KEY_BITS   = sft_pkg::DefKeyBits,
    parameter int unsigned VALUE_BITS = sft_pkg::DefValueBits
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Request stream.
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [sft_pkg::InDataW-1:0]  i_s_axis_tdata,  // [15:0] var_id, [31:16] new_value
    input  wire logic [sft_pkg::InUserW-1:0]  i_s_axis_tuser,  // [1:0] req_type
    // Result stream.
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic      [sft_pkg::OutDataW-1:0] o_m_axis_tdata,  // [15:0] read_value,
                                                               // [22:16] entry_count, [23] zero
    output logic      [sft_pkg::OutUserW-1:0] o_m_axis_tuser   // [0] found, [1] overflow
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_CMP   = 7'b0000100,
        ST_SH_RD = 7'b0001000,
        ST_SH_WR = 7'b0010000,
        ST_INS   = 7'b0100000,
        ST_RESP  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    sft_pkg::t_req         r_req,   n_req;
    logic [KEY_BITS-1:0]   r_key,   n_key;
    logic [VALUE_BITS-1:0] r_val,   n_val;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx,   n_idx;
    logic [CW-1:0]         r_sh,    n_sh;
    logic                  r_found, n_found;
    logic                  r_ovf,   n_ovf;
    logic [VALUE_BITS-1:0] r_rdval, n_rdval;

    // Storage ports.
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic                  w_key_we;
    logic                  w_val_we;
    logic [KEY_BITS-1:0]   w_key_wdata;
    logic [VALUE_BITS-1:0] w_val_wdata;
    logic [KEY_BITS-1:0]   w_key_rd;
    logic [VALUE_BITS-1:0] w_val_rd;

    // Stream fields brought to and from the parameter widths.
    logic [KEY_BITS+sft_pkg::VarIdW-1:0]     w_key_ext;
    logic [VALUE_BITS+sft_pkg::NewValueW-1:0] w_val_ext;
    logic [sft_pkg::ReadValueW+VALUE_BITS-1:0] w_rd_ext;
    logic [sft_pkg::EntryCountW+CW-1:0]       w_cnt_ext;
    logic [CW-1:0]                            w_sh_m1;

    assign w_key_ext = {{KEY_BITS{1'b0}}, i_s_axis_tdata[15:0]};
    assign w_val_ext = {{VALUE_BITS{1'b0}}, i_s_axis_tdata[31:16]};
    assign w_rd_ext  = {{sft_pkg::ReadValueW{1'b0}}, r_rdval};
    assign w_cnt_ext = {{sft_pkg::EntryCountW{1'b0}}, r_count};
    assign w_sh_m1   = r_sh - CW'(1);

    sft_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_key_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_key_rd)
    );

    sft_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_val_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_val_rd)
    );

    // Sequencer: scan for the sorted position, then read, update, or shift and insert; clear empties the count.
    always_comb begin
        logic decide;
        logic hit;

        n_state     = r_state;
        n_req       = r_req;
        n_key       = r_key;
        n_val       = r_val;
        n_count     = r_count;
        n_idx       = r_idx;
        n_sh        = r_sh;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_rdval     = r_rdval;
        w_rd_addr   = r_idx[AW-1:0];
        w_wr_addr   = r_idx[AW-1:0];
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_key_wdata = r_key;
        w_val_wdata = r_val;
        decide      = 1'b0;
        hit         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_req   = sft_pkg::t_req'(i_s_axis_tuser);
                    n_key   = w_key_ext[KEY_BITS-1:0];
                    n_val   = w_val_ext[VALUE_BITS-1:0];
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_ovf   = 1'b0;
                    n_rdval = '0;
                    case (sft_pkg::t_req'(i_s_axis_tuser))
                        sft_pkg::REQ_SET,
                        sft_pkg::REQ_GET: n_state = ST_RD;
                        sft_pkg::REQ_CLEAR: begin
                            n_count = '0;
                            n_state = ST_RESP;
                        end
                        default: n_state = ST_RESP;
                    endcase
                end
            end
            ST_RD: begin
                // Past the last stored entry: the position is the end of the table.
                if (r_idx >= r_count) begin
                    decide = 1'b1;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (w_key_rd < r_key) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_RD;
                end else begin
                    decide = 1'b1;
                    hit    = (w_key_rd == r_key);
                end
            end
            ST_SH_RD: begin
                w_rd_addr = w_sh_m1[AW-1:0];
                n_state   = ST_SH_WR;
            end
            ST_SH_WR: begin
                // Move the entry below up by one slot.
                w_wr_addr   = r_sh[AW-1:0];
                w_key_we    = 1'b1;
                w_val_we    = 1'b1;
                w_key_wdata = w_key_rd;
                w_val_wdata = w_val_rd;
                n_sh        = w_sh_m1;
                n_state     = (w_sh_m1 > r_idx) ? ST_SH_RD : ST_INS;
            end
            ST_INS: begin
                w_key_we = 1'b1;
                w_val_we = 1'b1;
                n_count  = r_count + CW'(1);
                n_state  = ST_RESP;
            end
            ST_RESP: begin
                if (i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Act on the position found by the scan.
        if (decide) begin
            n_state = ST_RESP;
            if (r_req == sft_pkg::REQ_SET) begin
                if (hit) begin
                    n_found  = 1'b1;
                    w_val_we = 1'b1;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_sh    = r_count;
                    n_state = (r_count > r_idx) ? ST_SH_RD : ST_INS;
                end
            end else if (hit) begin
                n_found = 1'b1;
                n_rdval = w_val_rd;
            end
        end
    end

    // State, entry count and result flags are reset; the request, pointers and read value are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_key   <= n_key;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_sh    <= n_sh;
        r_rdval <= n_rdval;
    end

    // Stream outputs.
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_RESP);
    assign o_m_axis_tdata  = {1'b0, w_cnt_ext[sft_pkg::EntryCountW-1:0],
                              w_rd_ext[sft_pkg::ReadValueW-1:0]};
    assign o_m_axis_tuser  = {r_ovf, r_found};

`ifndef ASSERT_OFF
    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A dropped insert is only reported with a full table.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_ovf) |-> (r_count == CW'(CAPACITY)))
        else $error("overflow reported with room left");

    // A result never reports both a hit and a dropped insert.
    a_found_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_found && r_ovf))
        else $error("found and overflow both set");

    // The shift pointer stays above the insert position while moving entries.
    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SH_RD || r_state == ST_SH_WR) |-> (r_sh > r_idx))
        else $error("shift pointer at or below insert position");

    // An insert adds exactly one entry by the next cycle.
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add one entry");
`endif

endmodule

`default_nettype wire

[rtl/sft_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the key and value stores of the sorted fact table; no dependencies.
`default_nettype none

module sft_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire
